[src/rpac_pkg.sv]
// Shared constants, register codes and arctangent table for the point rotator.
// No dependencies.
`default_nettype none

package rpac_pkg;

    localparam int CoordW   = 32;
    localparam int Steps    = 30;
    localparam int StepW    = $clog2(Steps);
    localparam int DxW      = CoordW + 1;
    localparam int TrigW    = 32;
    localparam int ProdW    = DxW + TrigW;
    localparam int SumW     = ProdW + 1;
    localparam int FinW     = SumW + 1;
    localparam int ResW     = FinW - 30;
    localparam int CordW    = 34;
    localparam int AngW     = 33;

    localparam logic signed [AngW-1:0]  PiQ29     = AngW'(1686629713);
    localparam logic signed [AngW-1:0]  HalfPiQ29 = AngW'(843314857);
    localparam logic signed [CordW-1:0] InvGain   = CordW'(652032874);
    localparam logic signed [TrigW-1:0] OneQ30    = TrigW'(1073741824);
    localparam logic signed [FinW-1:0]  RoundHalf = FinW'(1) <<< 29;
    localparam logic signed [ResW-1:0]  SatMax    = (ResW'(1) <<< (CoordW - 1)) - ResW'(1);
    localparam logic signed [ResW-1:0]  SatMin    = -SatMax - ResW'(1);

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_ANGLE    = 2'd2
    } t_cfg_idx;

    function automatic logic signed [AngW-1:0] atan_q29(input logic [StepW-1:0] i);
        logic signed [AngW-1:0] v;
        unique case (i)
            5'd0:    v = AngW'(421657428);
            5'd1:    v = AngW'(248918915);
            5'd2:    v = AngW'(131521918);
            5'd3:    v = AngW'(66762579);
            5'd4:    v = AngW'(33510843);
            5'd5:    v = AngW'(16771758);
            5'd6:    v = AngW'(8387925);
            5'd7:    v = AngW'(4194219);
            5'd8:    v = AngW'(2097141);
            5'd9:    v = AngW'(1048575);
            5'd10:   v = AngW'(524288);
            5'd11:   v = AngW'(262144);
            5'd12:   v = AngW'(131072);
            5'd13:   v = AngW'(65536);
            5'd14:   v = AngW'(32768);
            5'd15:   v = AngW'(16384);
            5'd16:   v = AngW'(8192);
            5'd17:   v = AngW'(4096);
            5'd18:   v = AngW'(2048);
            5'd19:   v = AngW'(1024);
            5'd20:   v = AngW'(512);
            5'd21:   v = AngW'(256);
            5'd22:   v = AngW'(128);
            5'd23:   v = AngW'(64);
            5'd24:   v = AngW'(32);
            5'd25:   v = AngW'(16);
            5'd26:   v = AngW'(8);
            5'd27:   v = AngW'(4);
            5'd28:   v = AngW'(2);
            5'd29:   v = AngW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/rotate_point_about_center_top.sv]
// Top level of the point rotator: config registers, iterative CORDIC, 4-stage datapath.
// Depends on rpac_pkg.
// Beats pass the subtract, multiply, sum and output registers; one per cycle unless stalled.
// The rate is set by the per-stage handshake; output stalls propagate back to o_s_axis_tready.
// An angle write starts the iterative CORDIC (one step per cycle, shared shift/add unit);
// o_s_axis_tready stays low until it finishes.
// Reset: centers clear, cosine one, sine zero, CORDIC idle, pipeline empty.
`default_nettype none

module rotate_point_about_center_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // [31:0] vertex_x, [63:32] vertex_y
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata    // [31:0] rotated_x, [63:32] rotated_y
);

    localparam int CoordW = rpac_pkg::CoordW;
    localparam int DxW    = rpac_pkg::DxW;
    localparam int TrigW  = rpac_pkg::TrigW;
    localparam int ProdW  = rpac_pkg::ProdW;
    localparam int SumW   = rpac_pkg::SumW;
    localparam int FinW   = rpac_pkg::FinW;
    localparam int ResW   = rpac_pkg::ResW;
    localparam int CordW  = rpac_pkg::CordW;
    localparam int AngW   = rpac_pkg::AngW;
    localparam int StepW  = rpac_pkg::StepW;

    logic signed [CoordW-1:0] r_center_x, r_center_y;
    logic signed [TrigW-1:0]  r_cos, r_sin;

    logic                     r_busy;
    logic [StepW-1:0]         r_step;
    logic signed [CordW-1:0]  r_cx, r_cy;
    logic signed [AngW-1:0]   r_cz;
    logic                     r_flip;

    logic signed [AngW-1:0]   ang_in, ang_sat, n_cz;
    logic                     n_flip;
    logic signed [CordW-1:0]  xs, ys, n_cx, n_cy, fin_x, fin_y;
    logic signed [AngW-1:0]   atan_v, n_z_step;
    logic                     cfg_angle;

    // angle pre-processing: clamp to +-pi, fold into +-pi/2
    always_comb begin
        ang_in  = AngW'($signed(i_cfg_data));
        ang_sat = ang_in;
        if (ang_in > rpac_pkg::PiQ29) begin
            ang_sat = rpac_pkg::PiQ29;
        end
        if (ang_in < -rpac_pkg::PiQ29) begin
            ang_sat = -rpac_pkg::PiQ29;
        end
        n_cz   = ang_sat;
        n_flip = 1'b0;
        if (ang_sat > rpac_pkg::HalfPiQ29) begin
            n_cz   = ang_sat - rpac_pkg::PiQ29;
            n_flip = 1'b1;
        end else if (ang_sat < -rpac_pkg::HalfPiQ29) begin
            n_cz   = ang_sat + rpac_pkg::PiQ29;
            n_flip = 1'b1;
        end
    end

    // one CORDIC micro-rotation
    always_comb begin
        xs     = r_cx >>> r_step;
        ys     = r_cy >>> r_step;
        atan_v = rpac_pkg::atan_q29(r_step);
        if (!r_cz[AngW-1]) begin
            n_cx     = r_cx - ys;
            n_cy     = r_cy + xs;
            n_z_step = r_cz - atan_v;
        end else begin
            n_cx     = r_cx + ys;
            n_cy     = r_cy - xs;
            n_z_step = r_cz + atan_v;
        end
        fin_x = r_flip ? -n_cx : n_cx;
        fin_y = r_flip ? -n_cy : n_cy;
    end

    assign cfg_angle = i_cfg_we && (rpac_pkg::t_cfg_idx'(i_cfg_idx) == rpac_pkg::CFG_ANGLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_cos      <= rpac_pkg::OneQ30;
            r_sin      <= '0;
            r_busy     <= 1'b0;
            r_step     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (rpac_pkg::t_cfg_idx'(i_cfg_idx))
                    rpac_pkg::CFG_CENTER_X: r_center_x <= $signed(i_cfg_data);
                    rpac_pkg::CFG_CENTER_Y: r_center_y <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (cfg_angle) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + StepW'(1);
                if (r_step == StepW'(rpac_pkg::Steps - 1)) begin
                    r_busy <= 1'b0;
                    r_cos  <= fin_x[TrigW-1:0];
                    r_sin  <= fin_y[TrigW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cfg_angle) begin
            r_cx   <= rpac_pkg::InvGain;
            r_cy   <= '0;
            r_cz   <= n_cz;
            r_flip <= n_flip;
        end else if (r_busy) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_z_step;
        end
    end

    // datapath pipeline
    logic                    r_v1, r_v2, r_v3, r_ov;
    logic                    en1, en2, en3, en_o, s_acc;
    logic signed [DxW-1:0]   r_dx, r_dy;
    logic signed [ProdW-1:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [SumW-1:0]  r_sx, r_sy;
    logic signed [CoordW-1:0] r_out_x, r_out_y;
    logic signed [CoordW-1:0] n_out_x, n_out_y;

    assign en_o            = !r_ov || i_m_axis_tready;
    assign en3             = !r_v3 || en_o;
    assign en2             = !r_v2 || en3;
    assign en1             = !r_v1 || en2;
    assign o_s_axis_tready = en1 && !r_busy;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    function automatic logic signed [CoordW-1:0] finish(
        input logic signed [SumW-1:0]   s,
        input logic signed [CoordW-1:0] c
    );
        logic signed [FinW-1:0] t;
        logic signed [ResW-1:0] r;
        logic signed [CoordW-1:0] o;
        t = FinW'(s) + rpac_pkg::RoundHalf + (FinW'(c) <<< 30);
        r = t[FinW-1:30];
        if (r > rpac_pkg::SatMax) begin
            o = rpac_pkg::SatMax[CoordW-1:0];
        end else if (r < rpac_pkg::SatMin) begin
            o = rpac_pkg::SatMin[CoordW-1:0];
        end else begin
            o = r[CoordW-1:0];
        end
        return o;
    endfunction

    assign n_out_x = finish(r_sx, r_center_x);
    assign n_out_y = finish(r_sy, r_center_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= s_acc;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en_o) begin
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_dx <= DxW'($signed(i_s_axis_tdata[31:0])) - DxW'(r_center_x);
            r_dy <= DxW'($signed(i_s_axis_tdata[63:32])) - DxW'(r_center_y);
        end
        if (en2) begin
            r_pxc <= ProdW'(r_dx) * ProdW'(r_cos);
            r_pys <= ProdW'(r_dy) * ProdW'(r_sin);
            r_pxs <= ProdW'(r_dx) * ProdW'(r_sin);
            r_pyc <= ProdW'(r_dy) * ProdW'(r_cos);
        end
        if (en3) begin
            r_sx <= SumW'(r_pxc) - SumW'(r_pys);
            r_sy <= SumW'(r_pxs) + SumW'(r_pyc);
        end
        if (en_o) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_out_y, r_out_x};

endmodule

`default_nettype wire
